// ----- rtl/core/maw_pkg.sv -----
// Shared definitions for the magnetic anomaly warning block: sizes, register
// indexes, source codes, controller states and the structs between modules.
// No dependencies.
package maw_pkg;

  localparam int WINDOW_DEPTH = 64;
  localparam int GRAD_LEN     = 8;

  localparam int SAMPLE_W = 34;
  localparam int WIDX_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int AVG_W    = 7;
  localparam int LEN_W    = (FILL_W > AVG_W) ? FILL_W : AVG_W;
  localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW_DEPTH);
  localparam int GIDX_W   = (GRAD_LEN > 1) ? $clog2(GRAD_LEN) : 1;
  localparam int GFILL_W  = $clog2(GRAD_LEN + 1);

  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int SQ_W       = 66;
  localparam int ROOT_STEPS = 35;
  localparam int ROOT_W     = ROOT_STEPS;
  localparam int RAD_W      = 2 * ROOT_STEPS;
  localparam int REM_W      = ROOT_W + 4;
  localparam int GACC_W     = 68;

  localparam int SQ_LAST   = 3;
  localparam int GRAD_LAST = 4;
  localparam int TONE_LAST = 1;

  localparam int CNT_MAX0 = (WINDOW_DEPTH > SUM_W) ? WINDOW_DEPTH : SUM_W;
  localparam int CNT_MAX1 = (CNT_MAX0 > ROOT_STEPS) ? CNT_MAX0 : ROOT_STEPS;
  localparam int CNT_MAX  = (CNT_MAX1 > GRAD_LEN) ? CNT_MAX1 : GRAD_LEN;
  localparam int CNT_W    = $clog2(CNT_MAX + 1);

  localparam int APB_ADDR_W = 6;
  localparam int APB_DATA_W = 64;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_WARN_SOURCE     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_AVG_WINDOW      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DECIMATION      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GRAD_SCALE      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GRAD_THRESHOLD  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ACCEL_THRESHOLD = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_GRAD_MAX        = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_TONE_COEFF      = 3'd7;

  localparam logic [1:0] SRC_PROBE1 = 2'd0;
  localparam logic [1:0] SRC_PROBE2 = 2'd1;
  localparam logic [1:0] SRC_ATOMIC = 2'd2;
  localparam logic [1:0] SRC_DIFF   = 2'd3;

  typedef struct packed {
    logic [31:0] b1_x;
    logic [31:0] b1_y;
    logic [31:0] b1_z;
    logic [31:0] b2_x;
    logic [31:0] b2_y;
    logic [31:0] b2_z;
    logic [31:0] atomic_field;
    logic [31:0] accel_x;
    logic [31:0] accel_y;
    logic [31:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic        warn;
    logic [31:0] gradient;
    logic [7:0]  tone;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  warn_source;
    logic [6:0]  avg_window;
    logic [7:0]  decimation;
    logic [31:0] grad_scale;
    logic [31:0] grad_threshold;
    logic [33:0] accel_threshold;
    logic [31:0] grad_max;
    logic [31:0] tone_coefficient;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRC_SQ,
    S_SRC_ROOT,
    S_PUSH,
    S_SUM,
    S_DIV,
    S_GRAD,
    S_HIST,
    S_ACC_SQ,
    S_ACC_ROOT,
    S_TONE,
    S_OUT
  } state_t;

  typedef struct packed {
    state_t           phase;
    logic [CNT_W-1:0] cnt;
    logic             load;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic               atomic;
    logic               eval;
    logic [LEN_W-1:0]   n_len;
    logic [GFILL_W-1:0] gfill;
    logic               out_free;
  } status_t;

endpackage

// ----- rtl/core/maw_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
module maw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                             wdata,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/core/maw_ctrl.sv -----
// Sequencing state machine of the magnetic anomaly warning block.
// Depends on maw_pkg.
module maw_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  maw_pkg::status_t status,
  output maw_pkg::cmd_t    cmd
);
  import maw_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = status.atomic ? S_PUSH : S_SRC_SQ;
        end
      end
      S_SRC_SQ: begin
        if (cnt == CNT_W'(SQ_LAST)) state_next = S_SRC_ROOT;
      end
      S_SRC_ROOT: begin
        if (cnt == CNT_W'(ROOT_STEPS - 1)) state_next = S_PUSH;
      end
      S_PUSH: begin
        state_next = status.eval ? S_SUM : S_IDLE;
      end
      S_SUM: begin
        if (cnt == CNT_W'(status.n_len)) state_next = S_DIV;
      end
      S_DIV: begin
        if (cnt == CNT_W'(SUM_W - 1)) state_next = S_GRAD;
      end
      S_GRAD: begin
        if (cnt == CNT_W'(GRAD_LAST)) state_next = S_HIST;
      end
      S_HIST: begin
        if (cnt + CNT_W'(1) == CNT_W'(status.gfill)) state_next = S_ACC_SQ;
      end
      S_ACC_SQ: begin
        if (cnt == CNT_W'(SQ_LAST)) state_next = S_ACC_ROOT;
      end
      S_ACC_ROOT: begin
        if (cnt == CNT_W'(ROOT_STEPS - 1)) state_next = S_TONE;
      end
      S_TONE: begin
        if (cnt == CNT_W'(TONE_LAST)) state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    if ((state_next != state) || (state == S_IDLE)) begin
      cnt_next = '0;
    end else begin
      cnt_next = cnt + CNT_W'(1);
    end
  end

  always_comb begin
    in_ready     = (state == S_IDLE);
    cmd.phase    = state;
    cmd.cnt      = cnt;
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.out_load = (state == S_OUT) && status.out_free;
  end

endmodule

// ----- rtl/core/maw_dp.sv -----
// Datapath of the magnetic anomaly warning block: squarer, square root,
// sample window, divider, gradient history, tone and the output register.
// Depends on maw_pkg and maw_ram.
module maw_dp (
  input  logic               clk,
  input  logic               rst,
  input  maw_pkg::cfg_t      cfg,
  input  maw_pkg::cmd_t      cmd,
  input  maw_pkg::in_item_t  in_data,
  output maw_pkg::status_t   status,
  output logic               out_valid,
  input  logic               out_ready,
  output maw_pkg::out_item_t out_data
);
  import maw_pkg::*;

  function automatic logic signed [32:0] comp_pick(input in_item_t it, input logic [1:0] k,
                                                   input logic accel, input logic [1:0] src);
    logic signed [32:0] a, b;
    begin
      a = '0;
      b = '0;
      case (k)
        2'd0: begin
          a = accel ? 33'($signed(it.accel_x)) : 33'($signed(it.b1_x));
          b = 33'($signed(it.b2_x));
        end
        2'd1: begin
          a = accel ? 33'($signed(it.accel_y)) : 33'($signed(it.b1_y));
          b = 33'($signed(it.b2_y));
        end
        2'd2: begin
          a = accel ? 33'($signed(it.accel_z)) : 33'($signed(it.b1_z));
          b = 33'($signed(it.b2_z));
        end
        default: begin
          a = '0;
          b = '0;
        end
      endcase
      if (accel || (src == SRC_PROBE1)) begin
        comp_pick = a;
      end else if (src == SRC_PROBE2) begin
        comp_pick = b;
      end else begin
        comp_pick = a - b;
      end
    end
  endfunction

  in_item_t item;

  logic signed [32:0] comp;
  logic [MUL_W-1:0]   comp_mag, mul_a, mul_b;
  logic [PROD_W-1:0]  prod;
  logic [SQ_W-1:0]    sq_acc;
  logic               is_sq, is_root;

  logic [RAD_W-1:0]  rad, rad_in;
  logic [REM_W-1:0]  rrem, rem_in, rem_sh, trial;
  logic [ROOT_W-1:0] root, root_in;
  logic              root_ge;

  logic [WIDX_W-1:0]          head, head_prev, rptr, ram_addr;
  logic [FILL_W-1:0]          fill;
  logic [7:0]                 decim;
  logic                       ram_we;
  logic [SAMPLE_W-1:0]        ram_rdata;
  logic signed [SAMPLE_W-1:0] sample_val;

  logic [LEN_W-1:0]         n_len;
  logic signed [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]         sum_mag, dvd, dvd_in, quot;
  logic [LEN_W-1:0]         drem, drem_in;
  logic [LEN_W:0]           drem_sh;
  logic                     div_ge;

  logic signed [SAMPLE_W-1:0] mean, prev_mean;
  logic signed [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]          diff_mag;
  logic [GACC_W-1:0]          gacc;
  logic [GACC_W-17:0]         gmag;
  logic signed [31:0]         g_new, grad;

  logic signed [31:0] hist [GRAD_LEN];
  logic [GIDX_W-1:0]  ghead, gstart, hidx, hidx_use;
  logic [GFILL_W:0]   gs_sum;
  logic [GFILL_W-1:0] gfill;
  logic signed [31:0] h_cur, h_first, first_h;
  logic [32:0]        h_mag;
  logic               h_fail, warn_acc, warn_fin;

  logic signed [31:0] tone_v;
  logic [31:0]        tone_mag;
  logic [7:0]         tone_low, tone_reg;

  // Component squaring and the multiplier shared by all products.
  assign is_sq   = (cmd.phase == S_SRC_SQ) || (cmd.phase == S_ACC_SQ);
  assign is_root = (cmd.phase == S_SRC_ROOT) || (cmd.phase == S_ACC_ROOT);
  assign comp    = comp_pick(item, cmd.cnt[1:0], cmd.phase == S_ACC_SQ, cfg.warn_source);
  assign comp_mag = comp[32] ? (~comp + 33'd1) : comp;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.phase)
      S_SRC_SQ, S_ACC_SQ: begin
        mul_a = comp_mag;
        mul_b = comp_mag;
      end
      S_GRAD: begin
        mul_a = (cmd.cnt == CNT_W'(2)) ? MUL_W'(diff_mag[SAMPLE_W:32])
                                       : {1'b0, diff_mag[31:0]};
        mul_b = {1'b0, cfg.grad_scale};
      end
      S_TONE: begin
        mul_a = {1'b0, tone_mag};
        mul_b = {1'b0, cfg.tone_coefficient};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.load) begin
      item <= in_data;
    end
    if (is_sq) begin
      if (cmd.cnt == '0) sq_acc <= '0;
      else               sq_acc <= sq_acc + SQ_W'(prod);
    end
  end

  // Square root, one result bit per cycle.
  always_comb begin
    rad_in  = (cmd.cnt == '0) ? RAD_W'(sq_acc) : rad;
    rem_in  = (cmd.cnt == '0) ? '0 : rrem;
    root_in = (cmd.cnt == '0) ? '0 : root;
    rem_sh  = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
    trial   = REM_W'({root_in, 2'b01});
    root_ge = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (is_root) begin
      rad  <= rad_in << 2;
      rrem <= root_ge ? (rem_sh - trial) : rem_sh;
      root <= {root_in[ROOT_W-2:0], root_ge};
    end
  end

  // Sample window.
  assign head_prev  = (head == '0) ? WIDX_W'(WINDOW_DEPTH - 1) : (head - WIDX_W'(1));
  assign sample_val = (cfg.warn_source == SRC_ATOMIC) ? SAMPLE_W'($signed(item.atomic_field))
                                                      : $signed(root[SAMPLE_W-1:0]);
  assign ram_we     = (cmd.phase == S_PUSH);
  assign ram_addr   = ram_we ? head : ((cmd.cnt == '0) ? head_prev : rptr);

  maw_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (sample_val),
    .rdata (ram_rdata)
  );

  always_comb begin
    n_len = (cfg.avg_window == '0) ? LEN_W'(1) : LEN_W'(cfg.avg_window);
    if (n_len > LEN_W'(WINDOW_DEPTH)) n_len = LEN_W'(WINDOW_DEPTH);
    if (n_len > LEN_W'(fill))         n_len = LEN_W'(fill);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      fill  <= '0;
      decim <= '0;
    end else if (ram_we) begin
      head  <= (head == WIDX_W'(WINDOW_DEPTH - 1)) ? '0 : (head + WIDX_W'(1));
      fill  <= (fill == FILL_W'(WINDOW_DEPTH)) ? fill : (fill + FILL_W'(1));
      decim <= status.eval ? 8'd0 : (decim + 8'd1);
    end
  end

  // Window sum: one read issued per cycle, each added in the next cycle.
  always_ff @(posedge clk) begin
    if (cmd.phase == S_SUM) begin
      rptr <= (ram_addr == '0) ? WIDX_W'(WINDOW_DEPTH - 1) : (ram_addr - WIDX_W'(1));
      if (cmd.cnt == '0) sum <= '0;
      else               sum <= sum + SUM_W'($signed(ram_rdata));
    end
  end

  // Restoring division of the sum magnitude by the sample count.
  always_comb begin
    sum_mag = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;
    dvd_in  = (cmd.cnt == '0) ? sum_mag : dvd;
    drem_in = (cmd.cnt == '0) ? '0 : drem;
    drem_sh = {drem_in, dvd_in[SUM_W-1]};
    div_ge  = (drem_sh >= {1'b0, n_len});
    quot    = sum[SUM_W-1] ? (~dvd + SUM_W'(1)) : dvd;
    mean    = $signed(quot[SAMPLE_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (cmd.phase == S_DIV) begin
      drem <= div_ge ? LEN_W'(drem_sh - {1'b0, n_len}) : drem_sh[LEN_W-1:0];
      dvd  <= {dvd_in[SUM_W-2:0], div_ge};
    end
  end

  // Gradient: difference of means times the scale, saturated.
  always_comb begin
    diff_mag = diff[SAMPLE_W] ? (~diff + (SAMPLE_W+1)'(1)) : diff;
    gmag     = gacc[GACC_W-1:16];
    if (diff[SAMPLE_W]) begin
      g_new = (gmag >= (GACC_W-16)'(64'h8000_0000)) ? 32'sh8000_0000 : -$signed(gmag[31:0]);
    end else begin
      g_new = (gmag >= (GACC_W-16)'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(gmag[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_mean <= '0;
      ghead     <= '0;
      gfill     <= '0;
    end else if (cmd.phase == S_GRAD) begin
      if (cmd.cnt == '0) begin
        prev_mean <= mean;
      end
      if (cmd.cnt == CNT_W'(GRAD_LAST)) begin
        ghead <= (ghead == GIDX_W'(GRAD_LEN - 1)) ? '0 : (ghead + GIDX_W'(1));
        gfill <= (gfill == GFILL_W'(GRAD_LEN)) ? gfill : (gfill + GFILL_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.phase == S_GRAD) begin
      case (cmd.cnt)
        CNT_W'(0): diff <= (SAMPLE_W+1)'(mean) - (SAMPLE_W+1)'(prev_mean);
        CNT_W'(2): gacc <= GACC_W'(prod);
        CNT_W'(3): gacc <= gacc + (GACC_W'(prod) << 32);
        CNT_W'(GRAD_LAST): begin
          hist[ghead] <= g_new;
          grad        <= g_new;
        end
        default: ;
      endcase
    end
  end

  // History walk from the oldest entry.
  always_comb begin
    gs_sum = (GFILL_W+1)'(ghead) + (GFILL_W+1)'(GRAD_LEN) - (GFILL_W+1)'(gfill);
    if (gs_sum >= (GFILL_W+1)'(GRAD_LEN)) gs_sum = gs_sum - (GFILL_W+1)'(GRAD_LEN);
    gstart   = GIDX_W'(gs_sum);
    hidx_use = (cmd.cnt == '0) ? gstart : hidx;
    h_cur    = hist[hidx_use];
    h_first  = (cmd.cnt == '0) ? h_cur : first_h;
    h_mag    = h_cur[31] ? (~33'(h_cur) + 33'd1) : 33'(h_cur);
    h_fail   = ((h_first > 0) && (h_cur < 0)) || ((h_first < 0) && (h_cur > 0)) ||
               (h_mag < {1'b0, cfg.grad_threshold});
  end

  always_ff @(posedge clk) begin
    if (cmd.phase == S_HIST) begin
      first_h  <= h_first;
      warn_acc <= ((cmd.cnt == '0) ? 1'b1 : warn_acc) & ~h_fail;
      hidx     <= (hidx_use == GIDX_W'(GRAD_LEN - 1)) ? '0 : (hidx_use + GIDX_W'(1));
    end
  end

  // Tone and final warning decision.
  always_comb begin
    tone_v   = (grad >= $signed(cfg.grad_max)) ? $signed(cfg.grad_max) : grad;
    tone_mag = tone_v[31] ? (~tone_v + 32'd1) : tone_v;
    tone_low = tone_v[31] ? (~prod[39:32] + 8'd1) : prod[39:32];
  end

  // The sum of squares lies within the squared limit exactly when its root is
  // below the limit, or equal to it with nothing left over.
  always_ff @(posedge clk) begin
    if (cmd.phase == S_TONE) begin
      if (cmd.cnt == '0) begin
        warn_fin <= warn_acc && ((root < ROOT_W'(cfg.accel_threshold)) ||
                                 ((root == ROOT_W'(cfg.accel_threshold)) && (rrem == '0)));
      end else begin
        tone_reg <= warn_fin ? tone_low : 8'd0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.warn     <= warn_fin;
      out_data.gradient <= grad;
      out_data.tone     <= tone_reg;
    end
  end

  always_comb begin
    status.atomic   = (cfg.warn_source == SRC_ATOMIC);
    status.eval     = ((decim + 8'd1) == cfg.decimation);
    status.n_len    = n_len;
    status.gfill    = gfill;
    status.out_free = !out_valid || out_ready;
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (fill <= FILL_W'(WINDOW_DEPTH)) && (gfill <= GFILL_W'(GRAD_LEN)))
    else $error("window or history fill beyond depth");

  a_quiet_tone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.warn) |-> (out_data.tone == 8'd0))
    else $error("tone set without a warning");

  a_decim_clear: assert property (@(posedge clk) disable iff (rst)
    ((cmd.phase == S_PUSH) && status.eval) |=> (decim == 8'd0))
    else $error("decimation counter out of step with evaluation");
`endif

endmodule

// ----- rtl/core/magnetic_anomaly_warning.sv -----
// Top level of the magnetic anomaly warning block: configuration registers
// and the controller and datapath. Depends on maw_pkg, maw_ctrl and maw_dp.
//
// Each transfer on the input channel is one calibrated sample set. The chosen
// source value (a probe magnitude, the atomic value or the magnitude of the
// probe difference) is pushed into a sliding window of up to WINDOW_DEPTH
// samples. On every decimation-th sample the window mean is formed, the
// scaled change of the mean enters the gradient history, and one result
// (warning flag, gradient and tone) is offered on the output channel; other
// samples produce no result. The block handles one item at a time. A sample
// that is not evaluated passes the squarer and the 35-step square root unit
// before the next input can be taken; with the atomic source it skips both.
// An evaluated sample also passes the window sum, one window memory read per
// cycle over the averaged samples, a 40-step divider for the mean, a walk
// over the gradient history and the shared square root unit again for the
// acceleration test. The finished result waits in an output register, so a
// slow consumer stalls the block only when a second result is ready before
// the first has been taken. Configuration sits on an APB-style port with
// 64-bit data, register i at byte address 8*i; it must be written only
// while the block is idle.
module magnetic_anomaly_warning (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  maw_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output maw_pkg::out_item_t                 out_data,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [maw_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [maw_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [maw_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import maw_pkg::*;

  cfg_t                 cfg;
  cmd_t                 cmd;
  status_t              status;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  // Registers sit on 8-byte boundaries; the low address bits are ignored.
  assign reg_idx = paddr[APB_ADDR_W-1:3];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.warn_source      <= SRC_PROBE1;
      cfg.avg_window       <= 7'd16;
      cfg.decimation       <= 8'd10;
      cfg.grad_scale       <= 32'd65536;
      cfg.grad_threshold   <= 32'd0;
      cfg.accel_threshold  <= '1;
      cfg.grad_max         <= 32'h7FFF_FFFF;
      cfg.tone_coefficient <= 32'd65536;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_WARN_SOURCE:     cfg.warn_source      <= pwdata[1:0];
        REG_AVG_WINDOW:      cfg.avg_window       <= pwdata[6:0];
        REG_DECIMATION:      cfg.decimation       <= pwdata[7:0];
        REG_GRAD_SCALE:      cfg.grad_scale       <= pwdata[31:0];
        REG_GRAD_THRESHOLD:  cfg.grad_threshold   <= pwdata[31:0];
        REG_ACCEL_THRESHOLD: cfg.accel_threshold  <= pwdata[33:0];
        REG_GRAD_MAX:        cfg.grad_max         <= pwdata[31:0];
        REG_TONE_COEFF:      cfg.tone_coefficient <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // Read-back is zero-extended to the data width.
  always_comb begin
    unique case (reg_idx)
      REG_WARN_SOURCE:     prdata = APB_DATA_W'(cfg.warn_source);
      REG_AVG_WINDOW:      prdata = APB_DATA_W'(cfg.avg_window);
      REG_DECIMATION:      prdata = APB_DATA_W'(cfg.decimation);
      REG_GRAD_SCALE:      prdata = APB_DATA_W'(cfg.grad_scale);
      REG_GRAD_THRESHOLD:  prdata = APB_DATA_W'(cfg.grad_threshold);
      REG_ACCEL_THRESHOLD: prdata = APB_DATA_W'(cfg.accel_threshold);
      REG_GRAD_MAX:        prdata = APB_DATA_W'(cfg.grad_max);
      REG_TONE_COEFF:      prdata = APB_DATA_W'(cfg.tone_coefficient);
      default:             prdata = '0;
    endcase
  end

  // The controller sequences each item; the datapath holds all arithmetic.
  maw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  maw_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .in_data   (in_data),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the magnetic anomaly warning block: a typed table
// of directed sample sets, then randomised phases, each result checked
// against an in-bench model of the warning logic or a hand-worked value.
// Depends on maw_pkg and magnetic_anomaly_warning.
`timescale 1ns / 100ps

module tb_top;
  import maw_pkg::*;

  localparam int EXP_DEPTH = 4096;
  localparam int MAX_ROWS  = 32;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  magnetic_anomaly_warning DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // 20 ns clock, high then low.
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Shadow copy of the configuration, kept in step with every register write.
  logic [1:0]  sh_src;
  int          sh_avg;
  logic [7:0]  sh_decim;
  logic [31:0] sh_scale;
  logic [31:0] sh_gthr;
  logic [33:0] sh_athr;
  longint      sh_gmax;
  logic [31:0] sh_coef;

  // Model state: the sample window, decimation counter, last mean and the
  // gradient history ring.
  longint      win_mem [WINDOW_DEPTH];
  int          win_fill;
  int          win_head;
  logic [7:0]  decim_cnt;
  longint      last_mean;
  longint      grad_mem [GRAD_LEN];
  int          grad_fill;
  int          grad_head;

  // Expected results, oldest at exp_rd.
  out_item_t   exp_fifo [EXP_DEPTH];
  int          exp_rd;
  int          exp_wr;
  int          mismatches;
  int          results_seen;
  int          items_sent;
  bit          calm;
  int          hold_left;

  function automatic int pending_count();
    return exp_wr - exp_rd;
  endfunction

  function automatic logic [63:0] umag(longint x);
    return (x < 0) ? 64'(-x) : 64'(x);
  endfunction

  // Exact sum of squares of a 3-vector.
  function automatic logic [127:0] sum_squares(longint x, longint y, longint z);
    logic [127:0] ux, uy, uz;
    ux = umag(x);
    uy = umag(y);
    uz = umag(z);
    return ux * ux + uy * uy + uz * uz;
  endfunction

  // Floor square root, 35 result bits.
  function automatic longint floor_root(logic [127:0] rad);
    logic [127:0] r, c;
    r = 0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= rad) r = c;
    end
    return longint'(r);
  endfunction

  function automatic longint sx(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  // Advances the model by one sample set; queues a result on an evaluation.
  task automatic predict_warning(in_item_t it);
    longint val, sum, mean, diff, g, v, first, h;
    logic [127:0] prod, acc, lim;
    logic [63:0] mag, t;
    logic [7:0] nxt;
    int n, oldest;
    bit warn;
    case (sh_src)
      SRC_PROBE1: val = floor_root(sum_squares(sx(it.b1_x), sx(it.b1_y), sx(it.b1_z)));
      SRC_PROBE2: val = floor_root(sum_squares(sx(it.b2_x), sx(it.b2_y), sx(it.b2_z)));
      SRC_ATOMIC: val = sx(it.atomic_field);
      default: val = floor_root(sum_squares(sx(it.b1_x) - sx(it.b2_x),
                                            sx(it.b1_y) - sx(it.b2_y),
                                            sx(it.b1_z) - sx(it.b2_z)));
    endcase
    win_mem[win_head] = val;
    win_head = (win_head + 1) % WINDOW_DEPTH;
    if (win_fill < WINDOW_DEPTH) win_fill++;

    nxt = decim_cnt + 8'd1;
    if (nxt != sh_decim) begin
      decim_cnt = nxt;
      return;
    end
    decim_cnt = 0;

    n = sh_avg;
    if (n < 1) n = 1;
    if (n > WINDOW_DEPTH) n = WINDOW_DEPTH;
    if (n > win_fill) n = win_fill;
    sum = 0;
    for (int k = 0; k < n; k++)
      sum += win_mem[(win_head + WINDOW_DEPTH - 1 - k) % WINDOW_DEPTH];
    mean = sum / longint'(n);

    diff = mean - last_mean;
    last_mean = mean;
    prod = 128'(umag(diff)) * 128'(sh_scale);
    mag = ((prod >> 80) != 0) ? '1 : prod[79:16];
    if (diff < 0)
      g = (mag >= 64'h8000_0000) ? -64'sh8000_0000 : -longint'(mag);
    else
      g = (mag >= 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(mag);

    grad_mem[grad_head] = g;
    grad_head = (grad_head + 1) % GRAD_LEN;
    if (grad_fill < GRAD_LEN) grad_fill++;

    warn = 1'b1;
    oldest = (grad_head + GRAD_LEN - grad_fill) % GRAD_LEN;
    first = grad_mem[oldest];
    for (int k = 0; k < grad_fill; k++) begin
      h = grad_mem[(oldest + k) % GRAD_LEN];
      if ((first > 0 && h < 0) || (first < 0 && h > 0) || umag(h) < 64'(sh_gthr))
        warn = 1'b0;
    end
    acc = sum_squares(sx(it.accel_x), sx(it.accel_y), sx(it.accel_z));
    lim = 128'(sh_athr) * 128'(sh_athr);
    if (acc > lim) warn = 1'b0;

    t = 0;
    if (warn) begin
      v = (g >= sh_gmax) ? sh_gmax : g;
      prod = 128'(umag(v)) * 128'(sh_coef);
      t = prod[95:32];
      if (v < 0) t = -t;
    end
    exp_fifo[exp_wr % EXP_DEPTH] = '{warn: warn, gradient: g[31:0], tone: t[7:0]};
    exp_wr++;
  endtask

  // APB write: setup cycle, then access cycle; the shadow follows.
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [63:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 3'b000};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      REG_WARN_SOURCE:     sh_src = value[1:0];
      REG_AVG_WINDOW:      sh_avg = value[6:0];
      REG_DECIMATION:      sh_decim = value[7:0];
      REG_GRAD_SCALE:      sh_scale = value[31:0];
      REG_GRAD_THRESHOLD:  sh_gthr = value[31:0];
      REG_ACCEL_THRESHOLD: sh_athr = value[33:0];
      REG_GRAD_MAX:        sh_gmax = sx(value[31:0]);
      default:             sh_coef = value[31:0];
    endcase
  endtask

  // Waits for every expected result, then lets any sample that produces no
  // result finish before the registers are touched.
  task automatic drain_block();
    while (pending_count() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    @(negedge clk);
  endtask

  // Offers one item from a falling edge; returns on the falling edge after
  // its transfer with valid still high, so back-to-back items need no gap.
  task automatic send_item(in_item_t it);
    if (!calm && $urandom_range(0, 99) < 7) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (!in_ready);
    predict_warning(it);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // A slowly drifting field with random content; a quarter of the items are
  // plain noise that breaks any trend.
  function automatic in_item_t make_item(longint level, bit wild_accel);
    in_item_t it;
    longint lvl;
    if ($urandom_range(0, 3) == 0) begin
      it = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
            rand_word(), rand_word(), rand_word(), rand_word(), rand_word()};
    end else begin
      lvl = level + longint'($urandom_range(0, 255)) - 128;
      it.b1_x = lvl[31:0];
      it.b1_y = $urandom_range(0, 4095);
      it.b1_z = -$urandom_range(0, 4095);
      it.b2_x = lvl[32:1];
      it.b2_y = -$urandom_range(0, 4095);
      it.b2_z = $urandom_range(0, 4095);
      it.atomic_field = lvl[31:0];
      it.accel_x = wild_accel ? rand_word() : 32'($urandom_range(0, 1 << 17));
      it.accel_y = -$urandom_range(0, 1 << 16);
      it.accel_z = $urandom_range(0, 1 << 16);
    end
    return it;
  endfunction

  // Receiver: decides ready at each falling edge; a requested hold-off
  // keeps it low for the counted number of cycles.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = calm || ($urandom_range(0, 99) >= 7);
      end
    end
  end

  // Each result transfer is compared with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_count() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: warn=%0b gradient=%h tone=%h",
                   out_data.warn, out_data.gradient, out_data.tone);
      end else if (out_data !== exp_fifo[exp_rd % EXP_DEPTH]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected warn=%0b gradient=%h tone=%h, got warn=%0b gradient=%h tone=%h",
                   exp_fifo[exp_rd % EXP_DEPTH].warn, exp_fifo[exp_rd % EXP_DEPTH].gradient,
                   exp_fifo[exp_rd % EXP_DEPTH].tone, out_data.warn, out_data.gradient,
                   out_data.tone);
        exp_rd++;
      end else begin
        exp_rd++;
      end
    end
  end

  // Hard limit on the run.
  initial begin
    #60ms;
    $display("tb_top NOT OK");
    $finish;
  end

  typedef struct {
    logic [1:0] src;
    in_item_t   item;
    bit         typed;
    out_item_t  result;
  } table_row_t;

  table_row_t directed [MAX_ROWS];
  int         n_rows;

  function automatic in_item_t fill(logic [31:0] b1, logic [31:0] b2,
                                    logic [31:0] atom, logic [31:0] acc);
    return {b1, b1, b1, b2, b2, b2, atom, acc, acc, acc};
  endfunction

  task automatic add_row(logic [1:0] src, in_item_t it, bit typed, out_item_t res);
    directed[n_rows] = '{src: src, item: it, typed: typed, result: res};
    n_rows++;
  endtask

  initial begin
    longint level, step;
    int phase, count;
    out_item_t none;
    none = '0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    calm = 1'b0;
    hold_left = 0;
    win_fill = 0;
    win_head = 0;
    decim_cnt = 0;
    last_mean = 0;
    grad_fill = 0;
    grad_head = 0;
    exp_rd = 0;
    exp_wr = 0;
    n_rows = 0;
    sh_src = SRC_PROBE1;
    sh_avg = 16;
    sh_decim = 10;
    sh_scale = 65536;
    sh_gthr = 0;
    sh_athr = '1;
    sh_gmax = 64'sh7FFF_FFFF;
    sh_coef = 65536;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: every sample evaluates and the mean is the sample itself,
    // so the gradient is simply the change of the selected value. The first
    // rows are worked out by hand: a unit step, a step up to full scale that
    // still agrees in sign, and a fall to the negative extreme whose
    // gradient saturates and breaks the sign agreement.
    add_row(SRC_ATOMIC, fill(0, 0, 32'h0001_0000, 0), 1, '{1'b1, 32'h0001_0000, 8'h01});
    add_row(SRC_ATOMIC, fill(0, 0, 32'h7FFF_FFFF, 0), 1, '{1'b1, 32'h7FFE_FFFF, 8'hFE});
    add_row(SRC_ATOMIC, fill(0, 0, 32'h8000_0000, 0), 1, '{1'b0, 32'h8000_0000, 8'h00});
    add_row(SRC_ATOMIC, fill(0, 0, 32'h0, 32'h8000_0000), 0, none);
    add_row(SRC_ATOMIC, fill(0, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF), 0, none);
    add_row(SRC_PROBE1, fill(32'h8000_0000, 0, 0, 0), 0, none);
    add_row(SRC_PROBE1, fill(32'h7FFF_FFFF, 0, 0, 0), 0, none);
    add_row(SRC_PROBE1, fill(32'h0, 32'h7FFF_FFFF, 0, 0), 0, none);
    add_row(SRC_PROBE2, fill(0, 32'h8000_0000, 0, 0), 0, none);
    add_row(SRC_PROBE2, fill(0, 32'h7FFF_FFFF, 0, 0), 0, none);
    add_row(SRC_DIFF, fill(32'h7FFF_FFFF, 32'h8000_0000, 0, 0), 0, none);
    add_row(SRC_DIFF, fill(32'h8000_0000, 32'h7FFF_FFFF, 0, 0), 0, none);
    add_row(SRC_DIFF, fill(32'h1234_5678, 32'h1234_5678, 0, 32'hFFFF_0000), 0, none);
    add_row(SRC_DIFF, fill(32'hFFFF_FFFF, 32'h0000_0001, 0, 32'h0000_0001), 0, none);

    write_reg(REG_WARN_SOURCE, SRC_ATOMIC);
    write_reg(REG_AVG_WINDOW, 1);
    write_reg(REG_DECIMATION, 1);
    write_reg(REG_GRAD_SCALE, 65536);
    write_reg(REG_GRAD_THRESHOLD, 0);
    write_reg(REG_ACCEL_THRESHOLD, 64'h3_FFFF_FFFF);
    write_reg(REG_GRAD_MAX, 64'h7FFF_FFFF);
    write_reg(REG_TONE_COEFF, 65536);

    for (int r = 0; r < n_rows; r++) begin
      if (directed[r].src != sh_src) begin
        in_valid = 1'b0;
        drain_block();
        write_reg(REG_WARN_SOURCE, directed[r].src);
      end
      send_item(directed[r].item);
      // A hand-worked row replaces the model's expectation with its own.
      if (directed[r].typed) begin
        exp_fifo[(exp_wr - 1) % EXP_DEPTH] = directed[r].result;
      end
    end
    in_valid = 1'b0;

    // Random phases, each under a fresh configuration written while idle.
    phase = 0;
    while (items_sent < 1350 + n_rows || results_seen < 60) begin
      drain_block();
      write_reg(REG_WARN_SOURCE, $urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0: write_reg(REG_AVG_WINDOW, 1);
        1: write_reg(REG_AVG_WINDOW, WINDOW_DEPTH);
        default: write_reg(REG_AVG_WINDOW, $urandom_range(1, WINDOW_DEPTH));
      endcase
      case ($urandom_range(0, 9))
        0: write_reg(REG_DECIMATION, 255);
        1: write_reg(REG_DECIMATION, $urandom_range(1, 255));
        default: write_reg(REG_DECIMATION, $urandom_range(1, 6));
      endcase
      write_reg(REG_GRAD_SCALE, ($urandom_range(0, 2) == 0) ? 64'(rand_word()) :
                                64'($urandom_range(1 << 12, 1 << 18)));
      write_reg(REG_GRAD_THRESHOLD, ($urandom_range(0, 4) == 0) ? 64'(rand_word()) :
                                    64'($urandom_range(0, 1 << 16)));
      case ($urandom_range(0, 3))
        0: write_reg(REG_ACCEL_THRESHOLD, 0);
        1: write_reg(REG_ACCEL_THRESHOLD, 64'h3_FFFF_FFFF);
        default: write_reg(REG_ACCEL_THRESHOLD, {$urandom_range(0, 3), $urandom});
      endcase
      write_reg(REG_GRAD_MAX, 64'(rand_word()));
      write_reg(REG_TONE_COEFF, ($urandom_range(0, 2) == 0) ? 64'(rand_word()) :
                                64'($urandom_range(0, 1 << 20)));

      // Phase one fills the block behind a stalled receiver; phase two runs
      // without random idling on either side.
      if (phase == 1) begin
        write_reg(REG_WARN_SOURCE, SRC_ATOMIC);
        write_reg(REG_DECIMATION, 1);
        hold_left = 400;
      end
      calm = (phase == 2);

      level = longint'($signed(32'($urandom_range(0, 1 << 24)))) - (1 << 23);
      step = longint'($urandom_range(1, 1 << 18));
      if ($urandom_range(0, 1)) step = -step;
      count = $urandom_range(120, 180);
      for (int k = 0; k < count; k++) begin
        send_item(make_item(level + step * k, $urandom_range(0, 9) == 0));
        // Once per phase the sender waits for every expected result.
        if (k == count / 2) begin
          in_valid = 1'b0;
          while (pending_count() != 0) @(posedge clk);
          @(negedge clk);
        end
      end
      in_valid = 1'b0;
      calm = 1'b0;
      phase++;
    end

    // Every sample has been transferred: wait for the outstanding results
    // and give the block time to show any result that should not come.
    while (pending_count() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && pending_count() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
